[src/mbrot_pkg.sv]
package mbrot_pkg;

  localparam int FRAC_BITS = 28;
  localparam int Z_W       = 32;
  localparam int CNT_W     = 16;
  localparam int GRAY_W    = 8;
  localparam int COORD_W   = 12;
  localparam int STEP_W    = 31;
  localparam int MAP_W     = COORD_W + STEP_W;
  localparam int PROD_W    = 2 * Z_W;
  localparam int WIDE_W    = PROD_W + 2;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [GRAY_W-1:0] GRAY_LAST = 8'd254;

  localparam logic signed [Z_W-1:0]    X_ORIGIN_RST = -32'sd536870912;
  localparam logic [STEP_W-1:0]        X_STEP_RST   = 31'd663036;
  localparam logic signed [Z_W-1:0]    Y_ORIGIN_RST = -32'sd300647711;
  localparam logic [STEP_W-1:0]        Y_STEP_RST   = 31'd751619;
  localparam logic [CNT_W-1:0]         ITER_LIM_RST = 16'd1020;

  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_X_STEP   = 3'd1;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd2;
  localparam logic [2:0] REG_Y_STEP   = 3'd3;
  localparam logic [2:0] REG_ITER_LIM = 3'd4;

  localparam logic signed [WIDE_W-1:0] Z_MAX_W = {{(WIDE_W-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] Z_MIN_W = {{(WIDE_W-Z_W+1){1'b1}}, {(Z_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] ESC_BOUND =
    $signed({{(WIDE_W-3){1'b0}}, 3'b100}) <<< FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_ADD,
    S_IT_MUL,
    S_IT_UPD,
    S_HOLD
  } mbrot_state_t;

  typedef struct packed {
    logic cap;
    logic map_mul;
    logic map_add;
    logic it_mul;
    logic it_upd;
    logic load_out;
  } mbrot_cmd_t;

  typedef struct packed {
    logic escape;
  } mbrot_status_t;

  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
    logic signed [Z_W-1:0] r;
    if (v > Z_MAX_W) begin
      r = Z_MAX_W[Z_W-1:0];
    end else if (v < Z_MIN_W) begin
      r = Z_MIN_W[Z_W-1:0];
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/mbrot_dp.sv]
module mbrot_dp
  import mbrot_pkg::*;
(
  input  logic                     clk,
  input  mbrot_cmd_t               cmd,
  output mbrot_status_t            status,
  input  logic [COORD_W-1:0]       pixel_col,
  input  logic [COORD_W-1:0]       pixel_row,
  input  logic signed [Z_W-1:0]    x_origin,
  input  logic [STEP_W-1:0]        x_step,
  input  logic signed [Z_W-1:0]    y_origin,
  input  logic [STEP_W-1:0]        y_step,
  input  logic [CNT_W-1:0]         iteration_limit,
  output logic [CNT_W-1:0]         iteration_count,
  output logic [GRAY_W-1:0]        gray_level
);

  logic [COORD_W-1:0]       col_r, row_r;
  logic [MAP_W-1:0]         cx_prod_r, cy_prod_r;
  logic signed [Z_W-1:0]    cx_r, cy_r, x_r, y_r;
  logic [PROD_W-1:0]        sq_x_r, sq_y_r;
  logic signed [PROD_W-1:0] xy_r;
  logic [CNT_W-1:0]         count_r, out_count_r;
  logic [GRAY_W-1:0]        gray_r, out_gray_r;

  logic [Z_W-1:0]           mag_x, mag_y;
  logic signed [WIDE_W-1:0] cx_wide, cy_wide, xx_w, yy_w, xy_sh, nx_w, ny_w, mag_sum;
  logic                     escape;

  assign mag_x = x_r[Z_W-1] ? (~x_r + 1'b1) : x_r;
  assign mag_y = y_r[Z_W-1] ? (~y_r + 1'b1) : y_r;

  assign cx_wide = WIDE_W'(x_origin) + $signed({{(WIDE_W-MAP_W){1'b0}}, cx_prod_r});
  assign cy_wide = WIDE_W'(y_origin) + $signed({{(WIDE_W-MAP_W){1'b0}}, cy_prod_r});

  assign xx_w    = $signed({2'b00, sq_x_r >> FRAC_BITS});
  assign yy_w    = $signed({2'b00, sq_y_r >> FRAC_BITS});
  assign xy_sh   = $signed({{(WIDE_W-PROD_W){xy_r[PROD_W-1]}}, xy_r}) >>> (FRAC_BITS - 1);
  assign mag_sum = xx_w + yy_w;
  assign nx_w    = xx_w - yy_w + WIDE_W'(cx_r);
  assign ny_w    = xy_sh + WIDE_W'(cy_r);

  assign escape        = (mag_sum > ESC_BOUND) || (count_r >= iteration_limit);
  assign status.escape = escape;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      col_r <= pixel_col;
      row_r <= pixel_row;
    end
    if (cmd.map_mul) begin
      cx_prod_r <= MAP_W'(col_r) * MAP_W'(x_step);
      cy_prod_r <= MAP_W'(row_r) * MAP_W'(y_step);
    end
    if (cmd.map_add) begin
      cx_r    <= sat_z(cx_wide);
      cy_r    <= sat_z(cy_wide);
      x_r     <= '0;
      y_r     <= '0;
      count_r <= '0;
      gray_r  <= '0;
    end
    if (cmd.it_mul) begin
      sq_x_r <= PROD_W'(mag_x) * PROD_W'(mag_x);
      sq_y_r <= PROD_W'(mag_y) * PROD_W'(mag_y);
      xy_r   <= PROD_W'(x_r) * PROD_W'(y_r);
    end
    if (cmd.it_upd && !escape) begin
      x_r     <= sat_z(nx_w);
      y_r     <= sat_z(ny_w);
      count_r <= count_r + 1'b1;
      gray_r  <= (gray_r == GRAY_LAST) ? '0 : gray_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_count_r <= count_r;
      out_gray_r  <= gray_r;
    end
  end

  assign iteration_count = out_count_r;
  assign gray_level      = out_gray_r;

endmodule

[src/mbrot_ctrl.sv]
module mbrot_ctrl
  import mbrot_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output mbrot_cmd_t    cmd,
  input  mbrot_status_t status
);

  mbrot_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_MAP_MUL;
        end
      end
      S_MAP_MUL: state_nxt = S_MAP_ADD;
      S_MAP_ADD: state_nxt = S_IT_MUL;
      S_IT_MUL:  state_nxt = S_IT_UPD;
      S_IT_UPD: begin
        if (!status.escape) begin
          state_nxt = S_IT_MUL;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
      end
      S_MAP_MUL: cmd.map_mul = 1'b1;
      S_MAP_ADD: cmd.map_add = 1'b1;
      S_IT_MUL:  cmd.it_mul  = 1'b1;
      S_IT_UPD: begin
        cmd.it_upd   = 1'b1;
        cmd.load_out = status.escape && out_free;
      end
      S_HOLD:    cmd.load_out = out_free;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_accept_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MAP_MUL))
    else $error("accepted pixel did not start coordinate mapping");

  a_iterate_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IT_UPD && !status.escape) |=> (state_r == S_IT_MUL))
    else $error("iteration stopped without escape");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && out_free) |=> out_valid_r)
    else $error("held result was not presented");

endmodule

[src/mandelbrot_escape_time_pixel.sv]
// One pixel is in flight at a time; after the input transfer the coordinates are mapped, then
// the pixel iterates until escape, with at most iteration_limit completed iterations; each
// iteration has one state for the three 32x32 products and one for the escape test and update.
// The next pixel is accepted in the cycle after its result is loaded into the output register.
// Synchronous active-low reset returns the controller to idle, drops out_tvalid and loads the
// register defaults (origin -2.0 - 1.12i, default steps, iteration limit 1020).
module mandelbrot_escape_time_pixel
  import mbrot_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,      // pixel_col[11:0], pixel_row[23:12]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,     // iteration_count[15:0], gray_level[23:16]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic signed [Z_W-1:0] x_origin_r, y_origin_r;
  logic [STEP_W-1:0]     x_step_r, y_step_r;
  logic [CNT_W-1:0]      iter_lim_r;
  logic                  cfg_wr;
  logic [2:0]            reg_idx;
  mbrot_cmd_t            cmd;
  mbrot_status_t         status;
  logic [CNT_W-1:0]      iteration_count;
  logic [GRAY_W-1:0]     gray_level;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= X_ORIGIN_RST;
      x_step_r   <= X_STEP_RST;
      y_origin_r <= Y_ORIGIN_RST;
      y_step_r   <= Y_STEP_RST;
      iter_lim_r <= ITER_LIM_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_X_ORIGIN: x_origin_r <= cfg_pwdata;
        REG_X_STEP:   x_step_r   <= cfg_pwdata[STEP_W-1:0];
        REG_Y_ORIGIN: y_origin_r <= cfg_pwdata;
        REG_Y_STEP:   y_step_r   <= cfg_pwdata[STEP_W-1:0];
        REG_ITER_LIM: iter_lim_r <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_ORIGIN: cfg_prdata = x_origin_r;
      REG_X_STEP:   cfg_prdata = {{(DATA_W-STEP_W){1'b0}}, x_step_r};
      REG_Y_ORIGIN: cfg_prdata = y_origin_r;
      REG_Y_STEP:   cfg_prdata = {{(DATA_W-STEP_W){1'b0}}, y_step_r};
      REG_ITER_LIM: cfg_prdata = {{(DATA_W-CNT_W){1'b0}}, iter_lim_r};
      default:      cfg_prdata = '0;
    endcase
  end

  mbrot_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  mbrot_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .status          (status),
    .pixel_col       (in_tdata[COORD_W-1:0]),
    .pixel_row       (in_tdata[2*COORD_W-1:COORD_W]),
    .x_origin        (x_origin_r),
    .x_step          (x_step_r),
    .y_origin        (y_origin_r),
    .y_step          (y_step_r),
    .iteration_limit (iter_lim_r),
    .iteration_count (iteration_count),
    .gray_level      (gray_level)
  );

  assign out_tdata = {gray_level, iteration_count};

endmodule
